>>> rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants for the three-tone sine synthesiser: field widths,
// register indexes, register reset values, parameter defaults and sample limits.
// ----------------------------------------------------------------------------
package tts_pkg;

	// parameter defaults
	localparam int OSC_COUNT_DEF  = 3;
	localparam int PHASE_BITS_DEF = 24;
	localparam int TABLE_BITS_DEF = 10;

	// field widths
	localparam int STEP_W    = 24;
	localparam int SHIFT_W   = 4;
	localparam int MIX_W     = 16;
	localparam int GAIN_W    = 17;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;
	localparam int IN_DAT_W  = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIX       = 3'd4;

	// register reset values
	localparam logic [STEP_W-1:0]  STEP_LOW_RST  = 24'd22827;
	localparam logic [STEP_W-1:0]  STEP_MID_RST  = 24'd45768;
	localparam logic [STEP_W-1:0]  STEP_HIGH_RST = 24'd91765;
	localparam logic [SHIFT_W-1:0] SHIFT_RST     = 4'd10;
	localparam logic [MIX_W-1:0]   MIX_RST       = 16'd21823;

	// positive and negative limits of an output sample
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

endpackage

>>> rtl/tts_sine_rom.sv
// ----------------------------------------------------------------------------
// tts_sine_rom
// Full-cycle sine table, Q1.15, with a registered read port. Contents are
// worked out at elaboration from a quarter wave in Q30 fixed point.
// ----------------------------------------------------------------------------
module tts_sine_rom #(
	parameter int TABLE_BITS = tts_pkg::TABLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic [TABLE_BITS-1:0]        addr,
	output logic signed [tts_pkg::SAMPLE_W-1:0] data
);

	localparam int ROM_SIZE = 1 << TABLE_BITS;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// round(32767 * sin(pi/2 * r / 2^qbits)), thirteen-term series in Q30
	function automatic logic [15:0] quarter_sine(input int r, input int qbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint acc;
		x = (64'(r) * HALF_PI_Q30 + ((64'd1 << qbits) >> 1)) >> qbits;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;   acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd342; acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd420; acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd506; acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd600; acc = acc + longint'(term);
		if (acc < 0) begin
			acc = 0;
		end
		v = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

	// mirror the quarter wave into a full cycle
	function automatic logic [15:0] sine_entry(input int k, input int tbits);
		int qbits;
		int quad;
		int r;
		logic [15:0] m;
		qbits = tbits - 2;
		quad = k >> qbits;
		r = k & ((1 << qbits) - 1);
		m = quad[0] ? quarter_sine((1 << qbits) - r, qbits) : quarter_sine(r, qbits);
		return quad[1] ? (~m + 16'd1) : m;
	endfunction

	logic signed [tts_pkg::SAMPLE_W-1:0] rom_tbl [ROM_SIZE];

	for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
		assign rom_tbl[k] = sine_entry(k, TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		data <= rom_tbl[addr];
	end

endmodule

>>> rtl/three_tone_sine_synth_core.sv
// ----------------------------------------------------------------------------
// three_tone_sine_synth_core
// Additive DDS oscillator bank: smoothed gain, OSC_COUNT phase accumulators,
// one sine table and one shared multiplier, saturated 16-bit output.
// ----------------------------------------------------------------------------
// A request taken in ST_IDLE runs ST_PHASE per oscillator, ST_SUM, ST_MUL1,
// ST_MUL2, ST_OUT; the next one is taken only in ST_IDLE. The single table
// read port (one oscillator a cycle) and the one multiplier used twice per
// sample set the pace. A waiting result does not block the next request, but
// holds the next result in ST_OUT. Reset (arst_n low) clears phases and gain
// at once and loads the register defaults; no clearing pass is needed.
module three_tone_sine_synth_core #(
	parameter int OSC_COUNT  = tts_pkg::OSC_COUNT_DEF,
	parameter int PHASE_BITS = tts_pkg::PHASE_BITS_DEF,
	parameter int TABLE_BITS = tts_pkg::TABLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tts_pkg::IN_DAT_W-1:0]     s_axis_tdata,  // [16:0] target_gain
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tts_pkg::SAMPLE_W-1:0]     m_axis_tdata,  // [15:0] sample
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tts_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int GAIN_W = tts_pkg::GAIN_W;
	localparam int STEP_W = tts_pkg::STEP_W;
	localparam int CNT_W  = (OSC_COUNT > 1) ? $clog2(OSC_COUNT) : 1;
	localparam int SUM_W  = tts_pkg::SAMPLE_W + $clog2(OSC_COUNT);
	localparam int A_W    = SUM_W + GAIN_W;
	localparam int B_W    = GAIN_W;
	localparam int P_W    = A_W + B_W;
	localparam int Q_W    = P_W + 1 - 32;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PHASE = 6'b000010,
		ST_SUM   = 6'b000100,
		ST_MUL1  = 6'b001000,
		ST_MUL2  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0]                 osc_q;
	logic [PHASE_BITS-1:0]            phase_q [OSC_COUNT];
	logic [GAIN_W-1:0]                gain_q;
	logic signed [SUM_W-1:0]          sum_q;
	logic                             neg_q;
	logic [P_W-1:0]                   mul_q;
	logic                             out_valid_q;
	logic [tts_pkg::SAMPLE_W-1:0]     out_data_q;

	logic [STEP_W-1:0]                step_low_q, step_mid_q, step_high_q;
	logic [tts_pkg::SHIFT_W-1:0]      shift_q;
	logic [tts_pkg::MIX_W-1:0]        mix_q;

	logic                             in_req;
	logic                             out_free;
	logic                             last_osc;
	logic [GAIN_W-1:0]                tgt;
	logic [GAIN_W-1:0]                d_up;
	logic [GAIN_W:0]                  d_dn;
	logic [GAIN_W-1:0]                gain_next;
	logic [STEP_W-1:0]                step_raw;
	logic [STEP_W+PHASE_BITS-1:0]     step_ext;
	logic [PHASE_BITS-1:0]            phase_next;
	logic signed [tts_pkg::SAMPLE_W-1:0] rom_data;
	logic [SUM_W-1:0]                 sum_abs;
	logic [A_W-1:0]                   mul_a;
	logic [B_W-1:0]                   mul_b;
	logic [P_W-1:0]                   product;
	logic [P_W:0]                     rounded;
	logic [Q_W-1:0]                   q_pos;
	logic [Q_W-1:0]                   q_neg;
	logic [tts_pkg::SAMPLE_W-1:0]     sample_sat;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign in_req   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign last_osc = (osc_q == CNT_W'(OSC_COUNT - 1));

	// one-pole gain step; downward step rounds up so the target is reached
	always_comb begin
		tgt  = s_axis_tdata[GAIN_W-1:0];
		d_up = tgt - gain_q;
		d_dn = {1'b0, gain_q - tgt} + (((GAIN_W+1)'(1) << shift_q) - (GAIN_W+1)'(1));
		if (tgt >= gain_q) begin
			gain_next = gain_q + (d_up >> shift_q);
		end else begin
			gain_next = gain_q - GAIN_W'(d_dn >> shift_q);
		end
	end

	// oscillators beyond the third have no step
	always_comb begin
		if (32'(osc_q) == 32'd0) begin
			step_raw = step_low_q;
		end else if (32'(osc_q) == 32'd1) begin
			step_raw = step_mid_q;
		end else if (32'(osc_q) == 32'd2) begin
			step_raw = step_high_q;
		end else begin
			step_raw = '0;
		end
		step_ext   = {{PHASE_BITS{1'b0}}, step_raw};
		phase_next = phase_q[osc_q] + step_ext[PHASE_BITS-1:0];
	end

	tts_sine_rom #(
		.TABLE_BITS(TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (phase_next[PHASE_BITS-1 -: TABLE_BITS]),
		.data (rom_data)
	);

	// shared multiplier: |sum| * gain, then that product * mix
	always_comb begin
		sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		if (state_q == ST_MUL2) begin
			mul_a = mul_q[A_W-1:0];
			mul_b = {1'b0, mix_q};
		end else begin
			mul_a = A_W'(sum_abs);
			mul_b = gain_q;
		end
		product = mul_a * mul_b;
	end

	// floor of a signed value over 2^32, then saturate
	always_comb begin
		rounded = (P_W+1)'(mul_q) + (P_W+1)'(33'h0FFFFFFFF);
		q_pos   = Q_W'(mul_q >> 32);
		q_neg   = rounded[P_W:32];
		if (neg_q) begin
			if (q_neg > Q_W'(32768)) begin
				sample_sat = tts_pkg::SAMPLE_MIN;
			end else begin
				sample_sat = ~q_neg[tts_pkg::SAMPLE_W-1:0] + 16'd1;
			end
		end else begin
			if (q_pos > Q_W'(32767)) begin
				sample_sat = tts_pkg::SAMPLE_MAX;
			end else begin
				sample_sat = q_pos[tts_pkg::SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_low_q  <= tts_pkg::STEP_LOW_RST;
			step_mid_q  <= tts_pkg::STEP_MID_RST;
			step_high_q <= tts_pkg::STEP_HIGH_RST;
			shift_q     <= tts_pkg::SHIFT_RST;
			mix_q       <= tts_pkg::MIX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tts_pkg::REG_STEP_LOW:  step_low_q  <= cfg_data[STEP_W-1:0];
				tts_pkg::REG_STEP_MID:  step_mid_q  <= cfg_data[STEP_W-1:0];
				tts_pkg::REG_STEP_HIGH: step_high_q <= cfg_data[STEP_W-1:0];
				tts_pkg::REG_SHIFT:     shift_q     <= cfg_data[tts_pkg::SHIFT_W-1:0];
				tts_pkg::REG_MIX:       mix_q       <= cfg_data[tts_pkg::MIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			osc_q       <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < OSC_COUNT; j++) begin
				phase_q[j] <= '0;
			end
		end else begin
			// a new result may replace one taken in the same cycle
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						gain_q  <= gain_next;
						osc_q   <= '0;
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					phase_q[osc_q] <= phase_next;
					if (last_osc) begin
						state_q <= ST_SUM;
					end else begin
						osc_q <= osc_q + CNT_W'(1);
					end
				end
				ST_SUM:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers; table data arrives in the cycle after its phase update
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: sum_q <= '0;
			ST_PHASE: begin
				if (osc_q != '0) begin
					sum_q <= sum_q + SUM_W'(rom_data);
				end
			end
			ST_SUM: sum_q <= sum_q + SUM_W'(rom_data);
			ST_MUL1: begin
				mul_q <= product;
				neg_q <= sum_q[SUM_W-1];
			end
			ST_MUL2: mul_q <= product;
			ST_OUT: begin
				if (out_free) begin
					out_data_q <= sample_sat;
				end
			end
			default: ;
		endcase
	end

	// a request always starts the oscillator sweep at the first oscillator
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> (state_q == ST_PHASE) && (osc_q == '0))
		else $error("request did not start the oscillator sweep");

	// smoothed gain stays between its old value and the target
	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> ((($past(gain_q) <= $past(tgt)) &&
			(gain_q >= $past(gain_q)) && (gain_q <= $past(tgt))) ||
			(($past(gain_q) > $past(tgt)) &&
			(gain_q < $past(gain_q)) && (gain_q >= $past(tgt)))))
		else $error("smoothed gain left its bounds");

	// oscillator counter never runs past the bank
	a_osc_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(osc_q) < OSC_COUNT)
		else $error("oscillator counter out of range");

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && !m_axis_tready |=>
			(state_q == ST_OUT) && $stable(out_data_q))
		else $error("waiting result overwritten");

endmodule
